// ===== hdl/stt_pkg.sv =====
// Shared types and codes for the segment timeline table.
`default_nettype none
package stt_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS_RD, S_INS_WR, S_LOC_RD, S_LOC_CHK,
    S_LOC_FRD, S_LOC_FIN, S_QRY_A, S_QRY_B, S_QRY_FIN, S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic dispatch;
    logic ins_rd;
    logic ins_wr;
    logic loc_rd;
    logic loc_chk;
    logic loc_frd;
    logic loc_fin;
    logic qry_a;
    logic qry_b;
    logic qry_fin;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       ins_last;
    logic       loc_hit;
    logic       loc_end;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/stt_ctrl.sv =====
// Sequencer for the segment timeline table.
`default_nettype none
module stt_ctrl
  import stt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        priority if ((stat.op == OP_APPEND || stat.op == OP_INSERT) && !stat.full)
          state_next = S_INS_RD;
        else if (stat.op == OP_LOCATE && !stat.empty)
          state_next = S_LOC_RD;
        else if (stat.op == OP_QUERY)
          state_next = S_QRY_A;
        else
          state_next = S_EMIT;
      end
      S_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_next = stat.ins_last ? S_EMIT : S_INS_RD;
      end
      S_LOC_RD: begin
        cmd.loc_rd = 1'b1;
        state_next = S_LOC_CHK;
      end
      S_LOC_CHK: begin
        cmd.loc_chk = 1'b1;
        state_next  = (stat.loc_hit || stat.loc_end) ? S_LOC_FRD : S_LOC_RD;
      end
      S_LOC_FRD: begin
        cmd.loc_frd = 1'b1;
        state_next  = S_LOC_FIN;
      end
      S_LOC_FIN: begin
        cmd.loc_fin = 1'b1;
        state_next  = S_EMIT;
      end
      S_QRY_A: begin
        cmd.qry_a  = 1'b1;
        state_next = S_QRY_B;
      end
      S_QRY_B: begin
        cmd.qry_b  = 1'b1;
        state_next = S_QRY_FIN;
      end
      S_QRY_FIN: begin
        cmd.qry_fin = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && stat.out_free) |=> state == S_IDLE)
    else $error("emit did not return to idle");
  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == S_DISPATCH)
    else $error("accepted word not dispatched");
  a_ins_needs_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH && stat.full) |=> state != S_INS_RD)
    else $error("insert started on full table");
`endif

endmodule
`default_nettype wire

// ===== hdl/stt_datapath.sv =====
// Tables, counters and result registers of the segment timeline table.
`default_nettype none
module stt_datapath
  import stt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [143:0]   s_tdata,
  input  wire logic [2:0]     s_tuser,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [183:0]        m_tdata,
  output logic [1:0]          m_tuser,
  input  wire cmd_t           cmd,
  output stat_t               stat
);

  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int EW  = $clog2(MAX_SLOTS);
  localparam int CMW = ((CW > 12) ? CW : 12) + 1;

  // latched input word
  logic [2:0]         op_q;
  logic signed [10:0] slot_q;
  logic [15:0]        bar_q;
  logic [31:0]        start_q;
  logic [31:0]        len_q;
  logic               drill_q;
  logic               trains_q;
  logic [47:0]        pos_q;

  logic [CW-1:0] count;
  logic [CW-1:0] j;
  logic [CW-1:0] at;
  logic [EW-1:0] li;
  logic [EW-1:0] f;
  logic [47:0]   qa;

  // pending result
  logic [1:0]  r_status;
  logic [9:0]  r_slot;
  logic [15:0] r_bar;
  logic        r_drill;
  logic [47:0] r_pos;
  logic [47:0] r_start;
  logic [47:0] r_len;

  // storage: entry {trains, drill, start, bar}; prefix entry zero is implied 0
  logic [49:0] ent_mem  [MAX_SLOTS];
  logic [47:0] pref_mem [MAX_SLOTS+1];
  logic [49:0] ent_rd;
  logic [47:0] pref_rd;
  logic        pref_zero;
  logic [47:0] pref_val;

  logic [EW-1:0] ent_ra;
  logic [CW-1:0] pref_ra;
  logic [CW-1:0] qry_a_idx, qry_b_idx;

  function automatic logic [CW-1:0] clamp_slot(input logic signed [11:0] s,
                                               input logic [CW-1:0] n);
    logic [CW-1:0] r;
    if (s[11])
      r = '0;
    else if (CMW'(unsigned'(s)) > CMW'(n))
      r = n;
    else
      r = CW'(unsigned'(s));
    return r;
  endfunction

  function automatic logic [9:0] sat_slot(input logic [CW-1:0] v);
    return (32'(v) > 32'd1023) ? 10'd1023 : 10'(v);
  endfunction

  assign qry_a_idx = clamp_slot(12'(slot_q), count);
  assign qry_b_idx = clamp_slot(12'(slot_q) + 12'sd1, count);
  assign pref_val  = pref_zero ? 48'd0 : pref_rd;

  always_comb begin
    ent_ra  = f;
    pref_ra = CW'(f);
    priority if (cmd.ins_rd) begin
      ent_ra  = EW'(j - CW'(1));
      pref_ra = j;
    end else if (cmd.loc_rd) begin
      pref_ra = CW'(li) + CW'(1);
    end else if (cmd.qry_a) begin
      pref_ra = qry_a_idx;
    end else if (cmd.qry_b) begin
      pref_ra = qry_b_idx;
    end
  end

  always_ff @(posedge clk) begin
    ent_rd    <= ent_mem[ent_ra];
    pref_rd   <= pref_mem[pref_ra];
    pref_zero <= (pref_ra == '0);
    if (cmd.ins_wr) begin
      ent_mem[EW'(j)] <= (j == at) ? {trains_q, drill_q, start_q, bar_q} : ent_rd;
      pref_mem[j + CW'(1)] <= pref_val + 48'(len_q);
    end
  end

  // locate arithmetic
  logic               hit;
  logic signed [50:0] sp;
  logic [47:0]        sp_sat;

  assign hit = $signed({pos_q[47], pos_q}) < $signed({1'b0, pref_val});
  assign sp  = $signed({19'd0, ent_rd[47:16]}) + $signed({{3{pos_q[47]}}, pos_q})
             - $signed({3'd0, pref_val});
  always_comb begin
    if (sp > 51'sh0_7FFF_FFFF_FFFF)       sp_sat = 48'h7FFF_FFFF_FFFF;
    else if (sp < -51'sh0_8000_0000_0000) sp_sat = 48'h8000_0000_0000;
    else                                  sp_sat = sp[47:0];
  end

  always_comb begin
    stat.op       = op_q;
    stat.full     = (count == CW'(MAX_SLOTS));
    stat.empty    = (count == '0);
    stat.ins_last = (j == at);
    stat.loc_hit  = hit;
    stat.loc_end  = (CW'(li) == count - CW'(1));
    stat.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= s_tuser;
      slot_q   <= s_tdata[10:0];
      bar_q    <= s_tdata[26:11];
      start_q  <= s_tdata[58:27];
      len_q    <= s_tdata[90:59];
      drill_q  <= s_tdata[91];
      trains_q <= s_tdata[92];
      pos_q    <= s_tdata[140:93];
    end
    if (cmd.dispatch) begin
      r_status <= ST_OK;
      r_slot   <= '0;
      r_bar    <= '0;
      r_drill  <= 1'b0;
      r_pos    <= '0;
      r_start  <= '0;
      r_len    <= '0;
      j        <= count;
      at       <= (op_q == OP_APPEND) ? count : clamp_slot(12'(slot_q), count);
      li       <= '0;
      if ((op_q == OP_APPEND || op_q == OP_INSERT) && count == CW'(MAX_SLOTS))
        r_status <= ST_FULL;
      if (op_q == OP_LOCATE && count == '0)
        r_status <= ST_EMPTY;
    end
    if (cmd.ins_wr && j != at) j <= j - CW'(1);
    if (cmd.loc_chk) begin
      if (hit || stat.loc_end) f <= li;
      else                     li <= li + EW'(1);
    end
    if (cmd.loc_fin) begin
      r_slot <= sat_slot(CW'(f));
      r_bar  <= ent_rd[15:0];
      if (ent_rd[48] && !ent_rd[49]) r_drill <= 1'b1;
      else                           r_pos   <= sp_sat;
    end
    if (cmd.qry_b) qa <= pref_val;
    if (cmd.qry_fin) begin
      r_slot  <= sat_slot(qry_a_idx);
      r_start <= qa;
      r_len   <= pref_val - qa;
    end
    if (cmd.emit) begin
      m_tuser <= r_status;
      m_tdata <= {2'd0, 11'(count), r_len, r_start, r_pos, r_drill, r_bar, r_slot};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.dispatch && op_q == OP_CLEAR) count <= '0;
      if (cmd.ins_wr && j == at)            count <= count + CW'(1);
      if (cmd.emit)          m_tvalid <= 1'b1;
      else if (m_tready)     m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SLOTS))
    else $error("entry count beyond table size");
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> (j >= at && j < CW'(MAX_SLOTS)))
    else $error("shift write outside insert range");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.loc_chk |-> CW'(li) < count)
    else $error("locate scan past last slot");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

// ===== hdl/segment_timeline_table.sv =====
// Top level of the segment timeline table.
`default_nettype none
// Keeps an ordered table of up to MAX_SLOTS segments plus prefix sums of their
// lengths, and serves one operation per input word (clear, append, insert,
// locate, query), returning exactly one result word each. Work is sequential:
// one word at a time, and a new word is taken while the previous result still
// waits on the output register. Both tables are memories with one read and one
// write port and a registered read, so every table step is a read state
// followed by a use state. Clear, full-table, empty locate and unknown codes
// go straight to the result; append/insert shift the entries from the end
// down to the slot; locate scans from slot 0 up to the found slot; query reads
// two prefix entries. No clearing pass after reset: entry zero of the prefix
// table is implied zero and all other entries are written before they can be
// read.
module segment_timeline_table
  import stt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // slot_index[10:0], bar_number[26:11], bar_start[58:27], bar_length[90:59],
  // drill_kind[91], trains_src[92], stream_position[140:93], zero fill
  input  wire logic [143:0] s_tdata,
  // operation[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // found_slot[9:0], source_bar_out[25:10], drill_out[26],
  // source_position[74:27], slot_start_out[122:75], slot_length_out[170:123],
  // entry_count[181:171], zero fill
  output logic [183:0]      m_tdata,
  // status[1:0]
  output logic [1:0]        m_tuser
);

  cmd_t  cmd;
  stat_t stat;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stt_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
`default_nettype wire

// ===== dv/segment_timeline_table_checker.sv =====
// Checker for the segment timeline table: models the table and compares result words.
module segment_timeline_table_checker
  import stt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [143:0] s_tdata,
  input  wire logic [2:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [183:0] m_tdata,
  input  wire logic [1:0]   m_tuser,
  output int                fail_count,
  output int                pending
);
  localparam int SLOTS = MAX_SLOTS_DEF;
  localparam longint POS_HI = (64'sd1 <<< 47) - 1;
  localparam longint POS_LO = -(64'sd1 <<< 47);

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [15:0] bar;
    logic        drill;
    logic [47:0] src_pos;
    logic [47:0] start;
    logic [47:0] length;
    logic [10:0] count;
  } result_t;

  logic [15:0] seg_bar [SLOTS];
  logic [31:0] seg_start [SLOTS];
  logic        seg_drill [SLOTS];
  logic        seg_trains [SLOTS];
  logic [47:0] prefix [SLOTS+1];
  int          seg_count;
  result_t     expected_q[$];

  assign pending = expected_q.size();

  function automatic int clamp_to(longint s, int hi);
    if (s < 0) return 0;
    if (s > hi) return hi;
    return int'(s);
  endfunction

  function automatic result_t table_op(logic [2:0] op, logic [143:0] d);
    result_t r;
    longint slot, pos, sp;
    logic [31:0] len;
    int at, f, a, b;
    r = '0;
    slot = longint'($signed(d[10:0]));
    len = d[90:59];
    pos = longint'($signed(d[140:93]));
    if (op == OP_CLEAR) begin
      seg_count = 0;
    end else if (op == OP_APPEND || op == OP_INSERT) begin
      if (seg_count >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        at = (op == OP_APPEND) ? seg_count : clamp_to(slot, seg_count);
        for (int i = seg_count; i > at; i--) begin
          seg_bar[i] = seg_bar[i-1]; seg_start[i] = seg_start[i-1];
          seg_drill[i] = seg_drill[i-1]; seg_trains[i] = seg_trains[i-1];
        end
        seg_bar[at] = d[26:11]; seg_start[at] = d[58:27];
        seg_drill[at] = d[91]; seg_trains[at] = d[92];
        for (int i = seg_count + 1; i > at + 1; i--) prefix[i] = prefix[i-1] + 48'(len);
        prefix[at+1] = prefix[at] + 48'(len);
        seg_count++;
      end
    end else if (op == OP_LOCATE) begin
      if (seg_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        f = seg_count - 1;
        for (int i = 0; i < seg_count; i++)
          if (pos < longint'({16'd0, prefix[i+1]})) begin
            f = i;
            break;
          end
        r.slot = (f > 1023) ? 10'd1023 : 10'(f);
        r.bar = seg_bar[f];
        if (seg_drill[f] && !seg_trains[f]) begin
          r.drill = 1'b1;
        end else begin
          sp = longint'({32'd0, seg_start[f]}) + (pos - longint'({16'd0, prefix[f]}));
          if (sp > POS_HI) sp = POS_HI;
          if (sp < POS_LO) sp = POS_LO;
          r.src_pos = sp[47:0];
        end
      end
    end else if (op == OP_QUERY) begin
      a = clamp_to(slot, seg_count);
      b = clamp_to(slot + 1, seg_count);
      r.slot = (a > 1023) ? 10'd1023 : 10'(a);
      r.start = prefix[a];
      r.length = prefix[b] - prefix[a];
    end
    r.count = 11'(seg_count);
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      seg_count = 0;
      prefix[0] = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) expected_q = {expected_q, table_op(s_tuser, s_tdata)};
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with none expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("status", e.status, m_tuser);
          compare_field("found_slot", e.slot, m_tdata[9:0]);
          compare_field("source_bar_out", e.bar, m_tdata[25:10]);
          compare_field("drill_out", e.drill, m_tdata[26]);
          compare_field("source_position", e.src_pos, m_tdata[74:27]);
          compare_field("slot_start_out", e.start, m_tdata[122:75]);
          compare_field("slot_length_out", e.length, m_tdata[170:123]);
          compare_field("entry_count", e.count, m_tdata[181:171]);
          compare_field("fill", 0, m_tdata[183:182]);
        end
      end
    end
  end
endmodule

// ===== dv/segment_timeline_table_test.sv =====
// Testbench top for the segment timeline table: stimulus, handshake pacing and verdict.
module segment_timeline_table_test;
  import stt_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [183:0] m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count;
  int           pending;
  longint       cycles = 0;

  always #5 clk = ~clk;

  segment_timeline_table u_top (.*);

  segment_timeline_table_checker u_chk (.*);

  // cycle limit: ~580 words at worst-case cost plus stalls, with wide margin
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10_000_000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern, changes character over time
  always @(posedge clk) begin
    if (cycles[9:8] == 2'd0) m_tready <= 1'b1;
    else if (cycles[9:8] == 2'd1) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= ($urandom_range(0, 1) != 0);
  end

  task automatic send_word(logic [2:0] op, logic [10:0] slot, logic [15:0] bar,
                           logic [31:0] bstart, logic [31:0] blen, logic drill,
                           logic trains, logic [47:0] pos);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'd0, pos, trains, drill, blen, bstart, bar, slot};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic gap();
    int g;
    g = $urandom_range(0, 3);
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [47:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(0, 1 << 22));
      2: return -48'($urandom_range(0, 1 << 20));
      default: return 48'($urandom_range(0, 1 << 26));
    endcase
  endfunction

  task automatic random_word(int fill_bias);
    logic [2:0] op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) op = OP_CLEAR;
    else if (r < fill_bias) op = ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
    else if (r < fill_bias + 25) op = OP_LOCATE;
    else if (r < 97) op = OP_QUERY;
    else op = 3'($urandom_range(5, 7));
    send_word(op,
              ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 40)),
              16'($urandom), $urandom,
              ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 1 << 20)),
              1'($urandom), 1'($urandom), rand_pos());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty table, extremes, every op, unknown codes
    send_word(OP_LOCATE, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0);
    send_word(OP_QUERY, 11'h400, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0);
    send_word(OP_APPEND, 11'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
              48'd0);
    send_word(OP_INSERT, 11'h7FF, 16'h1234, 32'd0, 32'h0001_0000, 1'b1, 1'b0, 48'd0);
    send_word(OP_INSERT, 11'h3FF, 16'h0001, 32'h8000_0000, 32'd0, 1'b1, 1'b1, 48'd0);
    send_word(OP_INSERT, 11'd1, 16'h00AA, 32'd5, 32'd7, 1'b0, 1'b1, 48'd0);
    send_word(OP_LOCATE, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'h8000_0000_0000);
    send_word(OP_LOCATE, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'h7FFF_FFFF_FFFF);
    send_word(OP_LOCATE, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'h0000_0001_0000);
    send_word(OP_LOCATE, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd3);
    send_word(OP_LOCATE, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
    for (int s = -1; s <= 4; s++)
      send_word(OP_QUERY, 11'(s), 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0);
    send_word(3'd5, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0);
    send_word(3'd7, 11'h7FF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
              48'hFFFF_FFFF_FFFF);
    send_word(OP_CLEAR, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0);
    send_word(OP_QUERY, 11'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0);
    // let the block drain fully once
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // random bursts: small tables mostly
    for (int i = 0; i < 560; i++) begin
      random_word((i % 150 < 40) ? 60 : 30);
      if ($urandom_range(0, 5) == 0) gap();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/stt_pkg.sv
hdl/stt_ctrl.sv
hdl/stt_datapath.sv
hdl/segment_timeline_table.sv
dv/segment_timeline_table_checker.sv
dv/segment_timeline_table_test.sv
